/* hdl/mnst_pkg.sv */
// ----------------------------------------------------------------------------
// mnst_pkg
// Shared constants, event codes and the flag unit's command and status types
// for the sustain tracker.
// ----------------------------------------------------------------------------
package mnst_pkg;

  localparam int unsigned NOTE_COUNT = 128;
  localparam int unsigned TIME_BITS  = 32;

  localparam int unsigned NoteIdxW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int unsigned KeyW     = 7;
  localparam int unsigned LevelW   = 7;
  localparam int unsigned ChanW    = 4;
  localparam int unsigned StampW   = 32;
  localparam int unsigned EntryW   = LevelW + TIME_BITS;

  localparam logic [KeyW-1:0]   PEDAL_CONTROLLER = 7'd64;
  localparam logic [LevelW-1:0] PEDAL_THRESHOLD  = 7'd64;

  typedef enum logic [1:0] {
    MODE_NOTE_ON  = 2'd0,
    MODE_NOTE_OFF = 2'd1,
    MODE_CTRL     = 2'd2,
    MODE_READ     = 2'd3
  } mode_e;

  typedef struct packed {
    logic                note_on;
    logic                note_off;
    logic                pedal_wr;
    logic                pedal_val;
    logic [NoteIdxW-1:0] idx;
  } flag_cmd_t;

  typedef struct packed {
    logic pressed;
    logic sounding;
    logic pedal;
  } flag_stat_t;

endpackage

/* hdl/mnst_ram.sv */
// ----------------------------------------------------------------------------
// mnst_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module mnst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                          clk_i,
  input  logic                                          en_i,
  input  logic                                          we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  addr_i,
  input  logic [Width-1:0]                              wdata_i,
  output logic [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/mnst_flags.sv */
// ----------------------------------------------------------------------------
// mnst_flags
// Pressed and sounding bit vectors plus the damper pedal flag. Pedal release
// clears every unpressed note at once.
// ----------------------------------------------------------------------------
module mnst_flags (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mnst_pkg::flag_cmd_t          cmd_i,
  input  logic [mnst_pkg::NoteIdxW-1:0] rd_idx_i,
  output mnst_pkg::flag_stat_t         stat_o
);

  logic [mnst_pkg::NOTE_COUNT-1:0] pressed_q, pressed_d;
  logic [mnst_pkg::NOTE_COUNT-1:0] sounding_q, sounding_d;
  logic                            pedal_q, pedal_d;

  always_comb begin
    pressed_d  = pressed_q;
    sounding_d = sounding_q;
    pedal_d    = pedal_q;
    if (cmd_i.note_on) begin
      pressed_d[cmd_i.idx]  = 1'b1;
      sounding_d[cmd_i.idx] = 1'b1;
    end
    if (cmd_i.note_off) begin
      pressed_d[cmd_i.idx] = 1'b0;
      if (!pedal_q) begin
        sounding_d[cmd_i.idx] = 1'b0;
      end
    end
    if (cmd_i.pedal_wr) begin
      pedal_d = cmd_i.pedal_val;
      // release drops every note no longer held by its key
      if (!cmd_i.pedal_val) begin
        sounding_d = sounding_q & pressed_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q  <= '0;
      sounding_q <= '0;
      pedal_q    <= 1'b0;
    end else begin
      pressed_q  <= pressed_d;
      sounding_q <= sounding_d;
      pedal_q    <= pedal_d;
    end
  end

  assign stat_o.pressed  = pressed_q[rd_idx_i];
  assign stat_o.sounding = sounding_q[rd_idx_i];
  assign stat_o.pedal    = pedal_q;

endmodule

/* hdl/midi_note_sustain_tracker.sv */
// ----------------------------------------------------------------------------
// midi_note_sustain_tracker
// Per-note MIDI state with damper pedal sustain for one listened channel.
// ----------------------------------------------------------------------------
// An item is taken in every clock cycle: busy_o stays low, and the result of
// an item is shown with done_o in the cycle right after the edge that took it.
// That delay is the registered read of the velocity and time
// RAM, a single-port memory that is read or written once per item; a note on
// writes it and its result is forwarded from the item itself. Pressed and
// sounding flags live in flip-flops cleared by reset, so a pedal release
// clears every unpressed note at the same edge. Results cannot be held off.
module midi_note_sustain_tracker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mnst_pkg::ChanW-1:0]   cfg_wdata_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   mode_i,
  input  logic [mnst_pkg::ChanW-1:0]   event_channel_i,
  input  logic [mnst_pkg::KeyW-1:0]    key_or_controller_i,
  input  logic [mnst_pkg::LevelW-1:0]  level_i,
  input  logic [mnst_pkg::StampW-1:0]  time_ms_i,
  output logic                         done_o,
  output logic [mnst_pkg::KeyW-1:0]    note_index_o,
  output logic                         is_pressed_o,
  output logic                         is_sounding_o,
  output logic [mnst_pkg::LevelW-1:0]  press_velocity_o,
  output logic [mnst_pkg::StampW-1:0]  press_time_o,
  output logic                         pedal_down_o
);

  logic [mnst_pkg::ChanW-1:0]    chan_q;
  logic                          accept;
  logic                          ours;
  logic                          key_valid;
  logic [mnst_pkg::NoteIdxW-1:0] idx;
  mnst_pkg::mode_e               mode;
  mnst_pkg::flag_cmd_t           cmd;
  mnst_pkg::flag_stat_t          stat;
  logic [mnst_pkg::TIME_BITS-1:0] time_in;
  logic [mnst_pkg::EntryW-1:0]   ram_rdata;
  logic [mnst_pkg::EntryW-1:0]   entry;
  logic [63:0]                   time_ext;

  logic                          done_q;
  logic [mnst_pkg::KeyW-1:0]     key_q;
  logic                          key_valid_q;
  logic                          fwd_q;
  logic [mnst_pkg::LevelW-1:0]   vel_q;
  logic [mnst_pkg::TIME_BITS-1:0] time_q;

  assign busy_o    = 1'b0;
  assign accept    = start_i && !busy_o;
  assign mode      = mnst_pkg::mode_e'(mode_i);
  assign ours      = (event_channel_i == chan_q);
  assign key_valid = ({1'b0, key_or_controller_i} < 8'(mnst_pkg::NOTE_COUNT));
  assign idx       = key_or_controller_i[mnst_pkg::NoteIdxW-1:0];
  assign time_in   = mnst_pkg::TIME_BITS'(64'(time_ms_i));

  always_comb begin
    cmd           = '0;
    cmd.idx       = idx;
    cmd.pedal_val = (level_i >= mnst_pkg::PEDAL_THRESHOLD);
    if (accept && ours) begin
      unique case (mode)
        mnst_pkg::MODE_NOTE_ON:  cmd.note_on  = key_valid;
        mnst_pkg::MODE_NOTE_OFF: cmd.note_off = key_valid;
        mnst_pkg::MODE_CTRL:
          cmd.pedal_wr = (key_or_controller_i == mnst_pkg::PEDAL_CONTROLLER);
        mnst_pkg::MODE_READ:     ;
        default:                 ;
      endcase
    end
  end

  mnst_flags u_flags (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .rd_idx_i (key_q[mnst_pkg::NoteIdxW-1:0]),
    .stat_o   (stat)
  );

  mnst_ram #(
    .Width (mnst_pkg::EntryW),
    .Depth (mnst_pkg::NOTE_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (accept && key_valid),
    .we_i    (cmd.note_on),
    .addr_i  (idx),
    .wdata_i ({level_i, time_in}),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
      done_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        chan_q <= cfg_wdata_i;
      end
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q       <= key_or_controller_i;
      key_valid_q <= key_valid;
      fwd_q       <= cmd.note_on;
      vel_q       <= level_i;
      time_q      <= time_in;
    end
  end

  // a note on wrote the RAM instead of reading it
  assign entry    = fwd_q ? {vel_q, time_q} : ram_rdata;
  assign time_ext = 64'(entry[mnst_pkg::TIME_BITS-1:0]);

  assign done_o           = done_q;
  assign note_index_o     = key_q;
  assign is_pressed_o     = key_valid_q && stat.pressed;
  assign is_sounding_o    = key_valid_q && stat.sounding;
  assign press_velocity_o = key_valid_q ? entry[mnst_pkg::EntryW-1 -: mnst_pkg::LevelW] : '0;
  assign press_time_o     = key_valid_q ? time_ext[mnst_pkg::StampW-1:0] : '0;
  assign pedal_down_o     = stat.pedal;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("item taken without a result in the next cycle");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result shown without an item");

  a_note_on_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.note_on |=> (is_pressed_o && is_sounding_o))
    else $error("note on did not set pressed and sounding");

  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.pedal_wr && !cmd.pedal_val) |=> (!pedal_down_o && (is_sounding_o == is_pressed_o)))
    else $error("pedal release left an unpressed note sounding");

  a_pressed_sounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_pressed_o) |-> is_sounding_o)
    else $error("pressed note reported silent");

endmodule

/* sim/mnst_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mnst_checker
// Watches the event, result and register channels of the sustain tracker,
// keeps its own note and pedal state, and checks every result in order.
// ----------------------------------------------------------------------------
module mnst_checker
  import mnst_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [ChanW-1:0]   cfg_wdata_i,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         mode_i,
  input  logic [ChanW-1:0]   event_channel_i,
  input  logic [KeyW-1:0]    key_or_controller_i,
  input  logic [LevelW-1:0]  level_i,
  input  logic [StampW-1:0]  time_ms_i,
  input  logic               done_i,
  input  logic [KeyW-1:0]    note_index_i,
  input  logic               is_pressed_i,
  input  logic               is_sounding_i,
  input  logic [LevelW-1:0]  press_velocity_i,
  input  logic [StampW-1:0]  press_time_i,
  input  logic               pedal_down_i,
  output int                 pending_o,
  output int                 mismatches_o
);

  typedef struct packed {
    logic [KeyW-1:0]   note;
    logic              pressed;
    logic              sounding;
    logic [LevelW-1:0] velocity;
    logic [StampW-1:0] stamp;
    logic              pedal;
  } note_report_t;

  note_report_t            report_queue[$];
  note_report_t            want;
  logic [ChanW-1:0]        listen_chan;
  logic [NOTE_COUNT-1:0]   pressed_map;
  logic [NOTE_COUNT-1:0]   sounding_map;
  logic [LevelW-1:0]       velocity_mem [NOTE_COUNT];
  logic [TIME_BITS-1:0]    stamp_mem [NOTE_COUNT];
  logic                    pedal_held;
  int                      faults;

  // applies one event to the note state and returns the report it produces
  function automatic note_report_t track_event(mode_e mode, logic [ChanW-1:0] chan,
                                               logic [KeyW-1:0] key,
                                               logic [LevelW-1:0] level,
                                               logic [StampW-1:0] now);
    note_report_t rep;
    logic         in_range;
    in_range = (int'(key) < int'(NOTE_COUNT));
    if (chan == listen_chan) begin
      case (mode)
        MODE_NOTE_ON: begin
          if (in_range) begin
            velocity_mem[key] = level;
            stamp_mem[key]    = TIME_BITS'(now);
            pressed_map[key]  = 1'b1;
            sounding_map[key] = 1'b1;
          end
        end
        MODE_NOTE_OFF: begin
          if (in_range) begin
            pressed_map[key] = 1'b0;
            if (!pedal_held) sounding_map[key] = 1'b0;
          end
        end
        MODE_CTRL: begin
          if (key == PEDAL_CONTROLLER) begin
            pedal_held = (level >= PEDAL_THRESHOLD);
            // pedal up releases every note whose key is not held
            if (!pedal_held) sounding_map = sounding_map & pressed_map;
          end
        end
        default: ;
      endcase
    end
    rep.note = key;
    if (in_range) begin
      rep.pressed  = pressed_map[key];
      rep.sounding = sounding_map[key];
      rep.velocity = velocity_mem[key];
      rep.stamp    = StampW'(stamp_mem[key]);
    end else begin
      rep.pressed  = 1'b0;
      rep.sounding = 1'b0;
      rep.velocity = '0;
      rep.stamp    = '0;
    end
    rep.pedal = pedal_held;
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listen_chan  = '0;
      pressed_map  = '0;
      sounding_map = '0;
      pedal_held   = 1'b0;
      faults       = 0;
      report_queue.delete();
    end else begin
      if (cfg_we_i) listen_chan = cfg_wdata_i;
      if (done_i) begin
        if (report_queue.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("unexpected result for note %0d at %0t", note_index_i, $realtime);
        end else begin
          want = report_queue.pop_front();
          if (note_index_i !== want.note || is_pressed_i !== want.pressed ||
              is_sounding_i !== want.sounding || press_velocity_i !== want.velocity ||
              press_time_i !== want.stamp || pedal_down_i !== want.pedal) begin
            faults++;
            if (faults <= 10) begin
              $display("mismatch at %0t: expected note %0d pressed %0b sounding %0b vel %0d time %h pedal %0b",
                       $realtime, want.note, want.pressed, want.sounding, want.velocity,
                       want.stamp, want.pedal);
              $display("             got note %0d pressed %0b sounding %0b vel %0d time %h pedal %0b",
                       note_index_i, is_pressed_i, is_sounding_i, press_velocity_i,
                       press_time_i, pedal_down_i);
            end
          end
        end
      end
      if (start_i && !busy_i)
        report_queue.push_back(track_event(mode_e'(mode_i), event_channel_i,
                                           key_or_controller_i, level_i, time_ms_i));
    end
    pending_o    <= report_queue.size();
    mismatches_o <= faults;
  end

endmodule

/* sim/tb_midi_note_sustain_tracker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_midi_note_sustain_tracker
// Drives note, pedal and read events into the sustain tracker across several
// listened channels; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_midi_note_sustain_tracker;
  import mnst_pkg::*;

  logic               clk_i               = 1'b0;
  logic               rst_ni              = 1'b0;
  logic               cfg_we_i            = 1'b0;
  logic [ChanW-1:0]   cfg_wdata_i         = '0;
  logic               start_i             = 1'b0;
  logic               busy_o;
  logic [1:0]         mode_i              = MODE_READ;
  logic [ChanW-1:0]   event_channel_i     = '0;
  logic [KeyW-1:0]    key_or_controller_i = '0;
  logic [LevelW-1:0]  level_i             = '0;
  logic [StampW-1:0]  time_ms_i           = '0;
  logic               done_o;
  logic [KeyW-1:0]    note_index_o;
  logic               is_pressed_o;
  logic               is_sounding_o;
  logic [LevelW-1:0]  press_velocity_o;
  logic [StampW-1:0]  press_time_o;
  logic               pedal_down_o;

  int                 pending;
  int                 mismatches;
  logic [ChanW-1:0]   listen_chan = '0;
  bit [NOTE_COUNT-1:0] written_notes = '0;
  bit                 steady = 1'b0;

  midi_note_sustain_tracker dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .mode_i              (mode_i),
    .event_channel_i     (event_channel_i),
    .key_or_controller_i (key_or_controller_i),
    .level_i             (level_i),
    .time_ms_i           (time_ms_i),
    .done_o              (done_o),
    .note_index_o        (note_index_o),
    .is_pressed_o        (is_pressed_o),
    .is_sounding_o       (is_sounding_o),
    .press_velocity_o    (press_velocity_o),
    .press_time_o        (press_time_o),
    .pedal_down_o        (pedal_down_o)
  );

  mnst_checker checker_i (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .start_i             (start_i),
    .busy_i              (busy_o),
    .mode_i              (mode_i),
    .event_channel_i     (event_channel_i),
    .key_or_controller_i (key_or_controller_i),
    .level_i             (level_i),
    .time_ms_i           (time_ms_i),
    .done_i              (done_o),
    .note_index_i        (note_index_o),
    .is_pressed_i        (is_pressed_o),
    .is_sounding_i       (is_sounding_o),
    .press_velocity_i    (press_velocity_o),
    .press_time_i        (press_time_o),
    .pedal_down_i        (pedal_down_o),
    .pending_o           (pending),
    .mismatches_o        (mismatches)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // presents one item, after a random pause unless in steady mode, and returns at the edge that takes it
  task automatic send_event(input mode_e mode, input logic [ChanW-1:0] chan,
                            input logic [KeyW-1:0] key, input logic [LevelW-1:0] level,
                            input logic [StampW-1:0] stamp);
    int gap;
    if ($urandom_range(0, 29) == 0) steady = !steady;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i             <= 1'b1;
    mode_i              <= mode;
    event_channel_i     <= chan;
    key_or_controller_i <= key;
    level_i             <= level;
    time_ms_i           <= stamp;
    do @(posedge clk_i); while (busy_o);
    if (mode == MODE_NOTE_ON && chan == listen_chan) written_notes[key] = 1'b1;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_listen(input logic [ChanW-1:0] chan);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= chan;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    listen_chan  = chan;
  endtask

  // mostly tracked-channel note traffic, mostly on keys 56 to 71 around the pedal
  task automatic random_event();
    mode_e             mode;
    logic [ChanW-1:0]  chan;
    logic [KeyW-1:0]   key;
    logic [LevelW-1:0] level;
    int                roll;
    chan  = ($urandom_range(0, 99) < 80) ? listen_chan : ChanW'($urandom_range(0, 15));
    key   = ($urandom_range(0, 99) < 65) ? KeyW'($urandom_range(56, 71))
                                         : KeyW'($urandom_range(0, 127));
    level = LevelW'($urandom_range(0, 127));
    roll  = $urandom_range(0, 99);
    if (roll < 35) mode = MODE_NOTE_ON;
    else if (roll < 65) mode = MODE_NOTE_OFF;
    else if (roll < 85) mode = MODE_CTRL;
    else mode = MODE_READ;
    if (mode == MODE_CTRL && $urandom_range(0, 99) < 70) begin
      key = PEDAL_CONTROLLER;
      if ($urandom_range(0, 1) == 0) level = LevelW'($urandom_range(60, 67));
    end
    // a note is only ever addressed once its velocity and time are stored
    if (!written_notes[key]) begin
      mode = MODE_NOTE_ON;
      chan = listen_chan;
    end
    send_event(mode, chan, key, level, $urandom());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, pedal threshold, foreign channel, sustain
    send_event(MODE_NOTE_ON,  listen_chan, PEDAL_CONTROLLER, 7'd127, 32'hFFFF_FFFF);
    send_event(MODE_NOTE_ON,  listen_chan, 7'd0,   7'd0,   32'h0000_0000);
    send_event(MODE_NOTE_ON,  listen_chan, 7'd127, 7'd1,   32'h8000_0001);
    send_event(MODE_READ,     4'd9,        PEDAL_CONTROLLER, 7'd0, 32'h0);
    send_event(MODE_CTRL,     listen_chan, PEDAL_CONTROLLER, PEDAL_THRESHOLD, 32'h5555_5555);
    send_event(MODE_NOTE_OFF, listen_chan, 7'd0,   7'd0,   32'h0);
    send_event(MODE_READ,     listen_chan, 7'd0,   7'd127, 32'hAAAA_AAAA);
    send_event(MODE_CTRL,     listen_chan, 7'd127, 7'd127, 32'h0);
    send_event(MODE_NOTE_OFF, 4'd15,       7'd127, 7'd0,   32'h0);
    send_event(MODE_NOTE_ON,  4'd15,       PEDAL_CONTROLLER, 7'd5, 32'h1234_5678);
    send_event(MODE_CTRL,     4'd3,        PEDAL_CONTROLLER, 7'd0, 32'h0);
    send_event(MODE_CTRL,     listen_chan, PEDAL_CONTROLLER, 7'd63, 32'h0);
    send_event(MODE_READ,     listen_chan, 7'd0,   7'd0,   32'h0);
    // release while already up
    send_event(MODE_CTRL,     listen_chan, PEDAL_CONTROLLER, 7'd0, 32'h0);
    send_event(MODE_NOTE_OFF, listen_chan, 7'd127, 7'd127, 32'h0);
    send_event(MODE_READ,     listen_chan, 7'd127, 7'd0,   32'h0);
    // retrigger of a note held only by the pedal
    send_event(MODE_NOTE_ON,  listen_chan, 7'd0,   7'd100, 32'h0000_00FF);
    send_event(MODE_CTRL,     listen_chan, PEDAL_CONTROLLER, 7'd127, 32'h0);
    send_event(MODE_NOTE_OFF, listen_chan, 7'd0,   7'd0,   32'h0);
    send_event(MODE_NOTE_ON,  listen_chan, 7'd0,   7'd64,  32'hFFFF_0000);
    send_event(MODE_NOTE_OFF, listen_chan, PEDAL_CONTROLLER, 7'd0, 32'h0);
    send_event(MODE_CTRL,     listen_chan, PEDAL_CONTROLLER, 7'd0, 32'h0);
    send_event(MODE_READ,     listen_chan, 7'd0,   7'd0,   32'h0);
    send_event(MODE_READ,     listen_chan, PEDAL_CONTROLLER, 7'd0, 32'h0);

    set_listen(4'd15);
    repeat (200) random_event();
    set_listen(4'd0);
    repeat (200) random_event();
    set_listen(ChanW'($urandom_range(1, 14)));
    repeat (200) random_event();
    set_listen(4'd15);
    repeat (200) random_event();
    drain();

    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
